FILE: hw/rtl/lce_pkg.sv
// shared types and constants for the lru cache with expiry
`default_nettype none
package lce_pkg;

  localparam int unsigned ENTRIES_DEF  = 64;
  localparam int unsigned KEY_BITS_DEF = 64;

  localparam logic [6:0]  MAX_ENTRIES_RST = 7'd64;
  localparam logic [15:0] TTL_RST         = 16'd30;

  localparam logic CFG_MAX_ENTRIES = 1'b0;
  localparam logic CFG_TTL         = 1'b1;

  typedef enum logic [2:0] {
    ACT_LOOKUP = 3'd0,
    ACT_INSERT = 3'd1,
    ACT_CLEAR  = 3'd2,
    ACT_SWEEP  = 3'd3,
    ACT_STATS  = 3'd4,
    ACT_TICK   = 3'd5
  } action_e;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_COMMIT = 2'd2
  } state_e;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    logic    eval;
    logic    commit;
    action_e act;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lru_cache_with_expiry_core.sv
// top level of the fully associative lru cache with minute-based expiry
// usage:
//   input channel (in_valid_i/in_ready_o) takes one item: action, key, score word
//   and frequency. output channel (out_valid_o/out_ready_i) returns one result
//   item per input item, in order.
//   lookup, insert and sweep scan the entry ram one entry per cycle through its
//   single read port before the result is registered; clear, stats, minute tick
//   and the unused action codes skip the scan and go straight to the commit step.
//   one item is in work at a time; the next is taken in the cycle after the
//   result has been moved into the output register.
//   the result register holds its item while out_ready_i is low; an item whose
//   work is done waits in its commit step until the register is free.
//   configuration (cfg_we_i, cfg_idx_i, cfg_data_i) is written while cfg_we_i is high:
//   index 0 max_entries, index 1 ttl_minutes.
//   reset clears all valid bits, counters and the minute tick, and loads
//   max_entries 64 and ttl_minutes 30; no clearing pass is needed.
`default_nettype none
module lru_cache_with_expiry_core #(
  parameter int unsigned ENTRIES  = lce_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lce_pkg::KEY_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [2:0]  action_i,
  input  wire logic [63:0] key_i,
  input  wire logic [63:0] score_word_i,
  input  wire logic [31:0] freq_in_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             hit_o,
  output logic [63:0]      score_out_o,
  output logic [31:0]      freq_out_o,
  output logic [6:0]       removed_count_o,
  output logic [31:0]      hit_total_o,
  output logic [31:0]      miss_total_o,
  output logic [6:0]       occupancy_o,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  lce_pkg::cmd_t              cmd;
  logic [$clog2(ENTRIES)-1:0] rd_idx, eval_idx;

  lce_ctrl #(
    .ENTRIES(ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_action_i(action_i),
    .out_ready_i(out_ready_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .cmd_o      (cmd),
    .rd_idx_o   (rd_idx),
    .eval_idx_o (eval_idx)
  );

  lce_dp #(
    .ENTRIES (ENTRIES),
    .KEY_BITS(KEY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .rd_idx_i       (rd_idx),
    .eval_idx_i     (eval_idx),
    .key_i          (key_i),
    .score_word_i   (score_word_i),
    .freq_in_i      (freq_in_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .hit_o          (hit_o),
    .score_out_o    (score_out_o),
    .freq_out_o     (freq_out_o),
    .removed_count_o(removed_count_o),
    .hit_total_o    (hit_total_o),
    .miss_total_o   (miss_total_o),
    .occupancy_o    (occupancy_o)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/lce_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none
module lce_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lce_ctrl.sv
// sequencer for the lru cache: accept, scan, commit
`default_nettype none
module lce_ctrl #(
  parameter int unsigned ENTRIES = lce_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  input  wire logic [2:0]                 in_action_i,
  input  wire logic                       out_ready_i,
  output logic                            in_ready_o,
  output logic                            out_valid_o,
  output lce_pkg::cmd_t                   cmd_o,
  output logic [$clog2(ENTRIES)-1:0]      rd_idx_o,
  output logic [$clog2(ENTRIES)-1:0]      eval_idx_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  lce_pkg::state_e  state_q, state_d;
  lce_pkg::action_e act_q, act_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [CW-1:0]    cnt_m1;
  logic             out_valid_q, out_valid_d;
  lce_pkg::action_e in_act;

  assign in_act     = lce_pkg::action_e'(in_action_i);
  assign cnt_m1     = cnt_q - CW'(1);
  assign rd_idx_o   = cnt_q[IW-1:0];
  assign eval_idx_o = cnt_m1[IW-1:0];
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lce_pkg::ST_IDLE;
      act_q       <= lce_pkg::ACT_STATS;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      act_q       <= act_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    act_d       = act_q;
    cnt_d       = cnt_q;
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    cmd_o.act   = act_q;
    case (state_q)
      lce_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          act_d      = in_act;
          cnt_d      = '0;
          if (in_act == lce_pkg::ACT_LOOKUP || in_act == lce_pkg::ACT_INSERT ||
              in_act == lce_pkg::ACT_SWEEP) begin
            state_d = lce_pkg::ST_SCAN;
          end else begin
            state_d = lce_pkg::ST_COMMIT;
          end
        end
      end
      lce_pkg::ST_SCAN: begin
        // read issued for cnt, data of cnt-1 evaluated
        cmd_o.rd_en = (cnt_q != CW'(ENTRIES));
        cmd_o.eval  = (cnt_q != '0);
        if (cnt_q == CW'(ENTRIES)) begin
          state_d = lce_pkg::ST_COMMIT;
        end else begin
          cnt_d = cnt_q + CW'(1);
        end
      end
      lce_pkg::ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          state_d      = lce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = lce_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lce_dp.sv
// datapath: entry ram, valid bits, scan trackers, counters and result register
`default_nettype none
module lce_dp #(
  parameter int unsigned ENTRIES  = lce_pkg::ENTRIES_DEF,
  parameter int unsigned KEY_BITS = lce_pkg::KEY_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire lce_pkg::cmd_t         cmd_i,
  input  wire logic [$clog2(ENTRIES)-1:0] rd_idx_i,
  input  wire logic [$clog2(ENTRIES)-1:0] eval_idx_i,
  input  wire logic [63:0]           key_i,
  input  wire logic [63:0]           score_word_i,
  input  wire logic [31:0]           freq_in_i,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_idx_i,
  input  wire logic [15:0]           cfg_data_i,
  output logic                       hit_o,
  output logic [63:0]                score_out_o,
  output logic [31:0]                freq_out_o,
  output logic [6:0]                 removed_count_o,
  output logic [31:0]                hit_total_o,
  output logic [31:0]                miss_total_o,
  output logic [6:0]                 occupancy_o
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned LW = (CW > 7) ? CW : 7;
  localparam int unsigned RW = KEY_BITS + 64 + 32 + 32 + 32;

  // ram word unpacked
  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  logic [RW-1:0]       ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0] r_key;
  logic [63:0]         r_score;
  logic [31:0]         r_freq, r_min, r_rec;

  assign {r_key, r_score, r_freq, r_min, r_rec} = ram_rdata;

  lce_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (cmd_i.rd_en),
    .raddr_i(rd_idx_i),
    .rdata_o(ram_rdata)
  );

  // control state
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]      occ_q, occ_d;
  logic [31:0]        minute_q, minute_d;
  logic [31:0]        seq_q, seq_d;
  logic [31:0]        hits_q, hits_d;
  logic [31:0]        miss_q, miss_d;
  logic [6:0]         max_q, max_d;
  logic [15:0]        ttl_q, ttl_d;
  logic               mf_q, mf_d, lf_q, lf_d, ff_q, ff_d;
  logic [CW-1:0]      rem_q, rem_d;

  // payload
  logic [KEY_BITS-1:0] k_q, k_d;
  logic [63:0]         sc_q, sc_d;
  logic [31:0]         fr_q, fr_d;
  logic [IW-1:0]       midx_q, midx_d, lidx_q, lidx_d, fidx_q, fidx_d;
  logic [63:0]         mscore_q, mscore_d;
  logic [31:0]         mfreq_q, mfreq_d, mmin_q, mmin_d, lrec_q, lrec_d;
  logic                hit_q, hit_d;
  logic [63:0]         so_q, so_d;
  logic [31:0]         fo_q, fo_d;
  logic [6:0]          ro_q, ro_d;

  // commit helpers
  logic [31:0]   seq_inc;
  logic          r_expired, m_expired;
  logic [LW-1:0] limit;
  logic          evict, m_ok, use_lru, have_slot;
  logic [IW-1:0] slot;

  assign seq_inc   = seq_q + 32'd1;
  assign r_expired = (minute_q - r_min) > {16'd0, ttl_q};
  assign m_expired = (minute_q - mmin_q) > {16'd0, ttl_q};
  assign limit     = (LW'(max_q) >= LW'(ENTRIES)) ? LW'(ENTRIES) : LW'(max_q);
  assign evict     = (LW'(occ_q) >= limit) && lf_q;
  assign m_ok      = mf_q && !(evict && (midx_q == lidx_q));
  assign use_lru   = evict && (!ff_q || (lidx_q < fidx_q));
  assign slot      = m_ok ? midx_q : (use_lru ? lidx_q : fidx_q);
  assign have_slot = m_ok || ff_q || evict;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      occ_q    <= '0;
      minute_q <= '0;
      seq_q    <= '0;
      hits_q   <= '0;
      miss_q   <= '0;
      max_q    <= lce_pkg::MAX_ENTRIES_RST;
      ttl_q    <= lce_pkg::TTL_RST;
      mf_q     <= 1'b0;
      lf_q     <= 1'b0;
      ff_q     <= 1'b0;
      rem_q    <= '0;
    end else begin
      valid_q  <= valid_d;
      occ_q    <= occ_d;
      minute_q <= minute_d;
      seq_q    <= seq_d;
      hits_q   <= hits_d;
      miss_q   <= miss_d;
      max_q    <= max_d;
      ttl_q    <= ttl_d;
      mf_q     <= mf_d;
      lf_q     <= lf_d;
      ff_q     <= ff_d;
      rem_q    <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q      <= k_d;
    sc_q     <= sc_d;
    fr_q     <= fr_d;
    midx_q   <= midx_d;
    lidx_q   <= lidx_d;
    fidx_q   <= fidx_d;
    mscore_q <= mscore_d;
    mfreq_q  <= mfreq_d;
    mmin_q   <= mmin_d;
    lrec_q   <= lrec_d;
    hit_q    <= hit_d;
    so_q     <= so_d;
    fo_q     <= fo_d;
    ro_q     <= ro_d;
  end

  always_comb begin
    valid_d  = valid_q;
    occ_d    = occ_q;
    minute_d = minute_q;
    seq_d    = seq_q;
    hits_d   = hits_q;
    miss_d   = miss_q;
    max_d    = max_q;
    ttl_d    = ttl_q;
    mf_d     = mf_q;
    lf_d     = lf_q;
    ff_d     = ff_q;
    rem_d    = rem_q;
    k_d      = k_q;
    sc_d     = sc_q;
    fr_d     = fr_q;
    midx_d   = midx_q;
    lidx_d   = lidx_q;
    fidx_d   = fidx_q;
    mscore_d = mscore_q;
    mfreq_d  = mfreq_q;
    mmin_d   = mmin_q;
    lrec_d   = lrec_q;
    hit_d    = hit_q;
    so_d     = so_q;
    fo_d     = fo_q;
    ro_d     = ro_q;
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = {k_q, sc_q, fr_q, minute_q, seq_inc};

    if (cfg_we_i) begin
      if (cfg_idx_i == lce_pkg::CFG_MAX_ENTRIES) begin
        max_d = cfg_data_i[6:0];
      end else begin
        ttl_d = cfg_data_i;
      end
    end

    if (cmd_i.load) begin
      k_d   = key_i[KEY_BITS-1:0];
      sc_d  = score_word_i;
      fr_d  = freq_in_i;
      mf_d  = 1'b0;
      lf_d  = 1'b0;
      ff_d  = 1'b0;
      rem_d = '0;
    end

    if (cmd_i.eval) begin
      if (valid_q[eval_idx_i]) begin
        if (!mf_q && (r_key == k_q)) begin
          mf_d     = 1'b1;
          midx_d   = eval_idx_i;
          mscore_d = r_score;
          mfreq_d  = r_freq;
          mmin_d   = r_min;
        end
        // oldest recency, lowest index on a tie
        if (!lf_q || (r_rec < lrec_q)) begin
          lf_d   = 1'b1;
          lidx_d = eval_idx_i;
          lrec_d = r_rec;
        end
        if (cmd_i.act == lce_pkg::ACT_SWEEP && r_expired) begin
          valid_d[eval_idx_i] = 1'b0;
          rem_d               = rem_q + CW'(1);
        end
      end else if (!ff_q) begin
        ff_d   = 1'b1;
        fidx_d = eval_idx_i;
      end
    end

    if (cmd_i.commit) begin
      hit_d = 1'b0;
      so_d  = '0;
      fo_d  = '0;
      ro_d  = '0;
      case (cmd_i.act)
        lce_pkg::ACT_LOOKUP: begin
          if (mf_q && !m_expired) begin
            seq_d     = seq_inc;
            ram_we    = 1'b1;
            ram_waddr = midx_q;
            ram_wdata = {k_q, mscore_q, mfreq_q, minute_q, seq_inc};
            hits_d    = (hits_q == '1) ? hits_q : hits_q + 32'd1;
            hit_d     = 1'b1;
            so_d      = mscore_q;
            fo_d      = mfreq_q;
          end else begin
            if (mf_q) begin
              valid_d[midx_q] = 1'b0;
              occ_d           = occ_q - CW'(1);
            end
            miss_d = (miss_q == '1) ? miss_q : miss_q + 32'd1;
          end
        end
        lce_pkg::ACT_INSERT: begin
          if (evict) begin
            valid_d[lidx_q] = 1'b0;
          end
          if (have_slot) begin
            seq_d         = seq_inc;
            ram_we        = 1'b1;
            valid_d[slot] = 1'b1;
          end
          occ_d = occ_q - CW'(evict) + CW'(have_slot && !m_ok);
        end
        lce_pkg::ACT_CLEAR: begin
          valid_d = '0;
          occ_d   = '0;
          hits_d  = '0;
          miss_d  = '0;
        end
        lce_pkg::ACT_SWEEP: begin
          occ_d = occ_q - rem_q;
          ro_d  = 7'(rem_q);
        end
        lce_pkg::ACT_TICK: begin
          minute_d = minute_q + 32'd1;
        end
        default: begin
        end
      endcase
    end
  end

  assign hit_o           = hit_q;
  assign score_out_o     = so_q;
  assign freq_out_o      = fo_q;
  assign removed_count_o = ro_q;
  assign hit_total_o     = hits_q;
  assign miss_total_o    = miss_q;
  assign occupancy_o     = 7'(occ_q);

endmodule
`default_nettype wire

FILE: dv/tb_top.sv
// self-checking testbench for the lru cache with expiry core
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned N_SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        hit;
    logic [63:0] score;
    logic [31:0] freq;
    logic [6:0]  removed;
    logic [31:0] hits;
    logic [31:0] misses;
    logic [6:0]  occ;
  } cache_res_t;

  typedef struct {
    logic [2:0]  act;
    logic [63:0] key;
    logic [63:0] score;
    logic [31:0] freq;
    logic        has_res;
    cache_res_t  res;
  } dir_row_t;

  logic        clk_i, rst_ni;
  logic        in_valid_i, in_ready_o;
  logic [2:0]  action_i;
  logic [63:0] key_i, score_word_i;
  logic [31:0] freq_in_i;
  logic        out_valid_o, out_ready_i;
  logic        hit_o;
  logic [63:0] score_out_o;
  logic [31:0] freq_out_o;
  logic [6:0]  removed_count_o, occupancy_o;
  logic [31:0] hit_total_o, miss_total_o;
  logic        cfg_we_i, cfg_idx_i;
  logic [15:0] cfg_data_i;

  lru_cache_with_expiry_core i_dut (.*);

  // predictor copy of the cache
  logic        m_valid [N_SLOTS];
  logic [63:0] m_key [N_SLOTS];
  logic [63:0] m_score [N_SLOTS];
  logic [31:0] m_freq [N_SLOTS];
  logic [31:0] m_min [N_SLOTS];
  logic [31:0] m_rec [N_SLOTS];
  logic [31:0] m_now, m_seq, m_hits, m_misses;
  logic [6:0]  m_max;
  logic [15:0] m_ttl;

  cache_res_t pending_res [$];
  logic       pending_chk [$];
  cache_res_t typed_res [$];
  int errors, cycles;
  logic [63:0] key_pool [8];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic int occ_count();
    int n = 0;
    for (int i = 0; i < N_SLOTS; i++) if (m_valid[i]) n++;
    return n;
  endfunction

  function automatic logic aged_out(int i);
    logic [31:0] age = m_now - m_min[i];
    return age > {16'd0, m_ttl};
  endfunction

  function automatic int slot_of(logic [63:0] k);
    for (int i = 0; i < N_SLOTS; i++) if (m_valid[i] && m_key[i] == k) return i;
    return -1;
  endfunction

  function automatic logic [31:0] sat_up(logic [31:0] v);
    return (v == 32'hFFFF_FFFF) ? v : v + 1;
  endfunction

  function automatic cache_res_t predict_cache(logic [2:0] act, logic [63:0] k,
                                               logic [63:0] sw, logic [31:0] fq);
    cache_res_t r = '0;
    int s, pick, lim;
    case (act)
      lce_pkg::ACT_LOOKUP: begin
        s = slot_of(k);
        if (s >= 0 && !aged_out(s)) begin
          m_seq++;
          m_min[s] = m_now;
          m_rec[s] = m_seq;
          m_hits = sat_up(m_hits);
          r.hit = 1;
          r.score = m_score[s];
          r.freq = m_freq[s];
        end else begin
          if (s >= 0) m_valid[s] = 0;
          m_misses = sat_up(m_misses);
        end
      end
      lce_pkg::ACT_INSERT: begin
        lim = (m_max < N_SLOTS) ? m_max : N_SLOTS;
        if (occ_count() >= lim) begin
          pick = -1;
          for (int i = 0; i < N_SLOTS; i++)
            if (m_valid[i] && (pick < 0 || m_rec[i] < m_rec[pick])) pick = i;
          if (pick >= 0) m_valid[pick] = 0;
        end
        s = slot_of(k);
        if (s < 0)
          for (int i = N_SLOTS - 1; i >= 0; i--) if (!m_valid[i]) s = i;
        if (s >= 0) begin
          m_seq++;
          m_valid[s] = 1;
          m_key[s] = k;
          m_score[s] = sw;
          m_freq[s] = fq;
          m_min[s] = m_now;
          m_rec[s] = m_seq;
        end
      end
      lce_pkg::ACT_CLEAR: begin
        for (int i = 0; i < N_SLOTS; i++) m_valid[i] = 0;
        m_hits = 0;
        m_misses = 0;
      end
      lce_pkg::ACT_SWEEP: begin
        for (int i = 0; i < N_SLOTS; i++)
          if (m_valid[i] && aged_out(i)) begin
            m_valid[i] = 0;
            r.removed++;
          end
      end
      lce_pkg::ACT_TICK: m_now++;
      default: ;
    endcase
    r.hits = m_hits;
    r.misses = m_misses;
    r.occ = occ_count();
    return r;
  endfunction

  // receiver: stalls on a pattern of its own
  initial begin
    cache_res_t got, want;
    logic typed;
    int ph = 0;
    out_ready_i = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        got = '{hit_o, score_out_o, freq_out_o, removed_count_o,
                hit_total_o, miss_total_o, occupancy_o};
        if (pending_res.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result item %p", got);
        end else begin
          want = pending_res.pop_front();
          typed = pending_chk.pop_front();
          if (got !== want || (typed && got !== typed_res[0])) begin
            errors++;
            if (errors <= 10) $display("result mismatch exp %p got %p", want, got);
          end
          if (typed) void'(typed_res.pop_front());
        end
      end
      ph++;
      // long free-run windows alternate with stall patterns
      if ((ph / 300) % 3 == 0) out_ready_i <= 1;
      else if ((ph / 300) % 3 == 1) out_ready_i <= (ph % 5) < 3;
      else out_ready_i <= ($urandom_range(0, 3) != 0);
    end
  end

  int burst_left = 0;

  // valid stays high inside a burst; it drops only for a gap or a drain
  task automatic send_item(logic [2:0] a, logic [63:0] k, logic [63:0] sw,
                           logic [31:0] fq, logic typed, cache_res_t tr);
    cache_res_t p;
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid_i <= 0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    p = predict_cache(a, k, sw, fq);
    pending_res.push_back(p);
    pending_chk.push_back(typed);
    if (typed) typed_res.push_back(tr);
    in_valid_i <= 1;
    action_i <= a;
    key_i <= k;
    score_word_i <= sw;
    freq_in_i <= fq;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_out();
    in_valid_i <= 0;
    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
    if (idx == lce_pkg::CFG_MAX_ENTRIES) m_max = val[6:0];
    else m_ttl = val;
    @(posedge clk_i);
  endtask

  function automatic logic [63:0] pick_key();
    return ($urandom_range(0, 3) != 0) ? key_pool[$urandom_range(0, 7)]
                                       : {$urandom, $urandom};
  endfunction

  task automatic random_phase(int n, int lookup_w);
    logic [2:0] a;
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < lookup_w) a = lce_pkg::ACT_LOOKUP;
      else if (r < 75) a = lce_pkg::ACT_INSERT;
      else if (r < 85) a = lce_pkg::ACT_TICK;
      else if (r < 91) a = lce_pkg::ACT_SWEEP;
      else if (r < 95) a = lce_pkg::ACT_STATS;
      else if (r < 97) a = lce_pkg::ACT_CLEAR;
      else a = 3'($urandom_range(6, 7));
      send_item(a, pick_key(), {$urandom, $urandom}, $urandom, 0, '0);
    end
  endtask

  dir_row_t dir_rows [$];

  initial begin
    dir_row_t row;
    errors = 0;
    cycles = 0;
    rst_ni = 0;
    in_valid_i = 0;
    action_i = '0;
    key_i = '0;
    score_word_i = '0;
    freq_in_i = '0;
    cfg_we_i = 0;
    cfg_idx_i = lce_pkg::CFG_MAX_ENTRIES;
    cfg_data_i = '0;
    for (int i = 0; i < N_SLOTS; i++) m_valid[i] = 0;
    m_now = 0; m_seq = 0; m_hits = 0; m_misses = 0;
    m_max = lce_pkg::MAX_ENTRIES_RST;
    m_ttl = lce_pkg::TTL_RST;
    for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom};
    key_pool[0] = '0;
    key_pool[1] = '1;

    // directed rows; results typed in only where plain to read
    dir_rows = '{
      '{lce_pkg::ACT_STATS,  64'd0, 64'd0, 32'd0, 1, '{0, 0, 0, 0, 0, 0, 0}},
      '{lce_pkg::ACT_LOOKUP, 64'd0, 64'd0, 32'd0, 1, '{0, 0, 0, 0, 0, 1, 0}},
      '{lce_pkg::ACT_INSERT, '1, '1, '1, 1, '{0, 0, 0, 0, 0, 1, 1}},
      '{lce_pkg::ACT_LOOKUP, '1, 64'd0, 32'd0, 1, '{1, '1, '1, 0, 1, 1, 1}},
      '{lce_pkg::ACT_INSERT, 64'd0, 64'd0, 32'd0, 0, '0},
      '{lce_pkg::ACT_INSERT, 64'd0, 64'h5a5a, 32'd7, 0, '0},
      '{lce_pkg::ACT_LOOKUP, 64'd0, 64'd0, 32'd0, 0, '0},
      '{lce_pkg::ACT_SWEEP,  64'd0, 64'd0, 32'd0, 0, '0},
      '{3'd6,                '1, '1, '1, 0, '0},
      '{3'd7,                64'd0, 64'd0, 32'd0, 0, '0},
      '{lce_pkg::ACT_CLEAR,  64'd0, 64'd0, 32'd0, 1, '{0, 0, 0, 0, 0, 0, 0}}
    };
    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.act, row.key, row.score, row.freq, row.has_res, row.res);
    end
    // expiry: insert, age past ttl, then lookup and sweep
    drain_out();
    write_reg(lce_pkg::CFG_TTL, 16'd0);
    send_item(lce_pkg::ACT_INSERT, 64'h11, 64'h22, 32'h33, 0, '0);
    send_item(lce_pkg::ACT_INSERT, 64'h44, 64'h55, 32'h66, 0, '0);
    send_item(lce_pkg::ACT_TICK, 0, 0, 0, 0, '0);
    send_item(lce_pkg::ACT_LOOKUP, 64'h11, 0, 0, 0, '0);
    send_item(lce_pkg::ACT_SWEEP, 0, 0, 0, 0, '0);
    drain_out();
    // zero limit
    write_reg(lce_pkg::CFG_MAX_ENTRIES, 16'd0);
    write_reg(lce_pkg::CFG_TTL, 16'hFFFF);
    for (int i = 0; i < 3; i++) send_item(lce_pkg::ACT_INSERT, key_pool[i], i, i, 0, '0);
    drain_out();

    write_reg(lce_pkg::CFG_MAX_ENTRIES, 16'd4);
    write_reg(lce_pkg::CFG_TTL, 16'd3);
    random_phase(120, 40);
    drain_out();
    write_reg(lce_pkg::CFG_MAX_ENTRIES, 16'd127);
    write_reg(lce_pkg::CFG_TTL, 16'd1);
    random_phase(120, 35);
    drain_out();
    write_reg(lce_pkg::CFG_MAX_ENTRIES, 16'd1);
    write_reg(lce_pkg::CFG_TTL, 16'd0);
    random_phase(60, 40);
    drain_out();
    write_reg(lce_pkg::CFG_MAX_ENTRIES, 16'd64);
    write_reg(lce_pkg::CFG_TTL, 16'hFFFF);
    random_phase(100, 30);
    drain_out();

    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire
